// ===== hw/rtl/hsw_pkg.sv =====
`default_nettype none

package hsw_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int TEMP_BITS  = 32;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int SIZE_W    = 9;
    localparam int MIN_SIZE  = 3;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS = 16;

    localparam int DIFF_W = TEMP_BITS + 3;
    localparam int PROD_W = DIFF_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - FRAC_BITS;
    localparam int UPD_W  = RND_W + 1;
    localparam int NT_W   = UPD_W + 1;
    localparam int ROUND_HALF = 2 ** (FRAC_BITS - 1);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int PIPE_STAGES = 4;
    localparam int PIPE_CNT_W = $clog2(PIPE_STAGES + 1);
    localparam int CREDIT_W = FIFO_CNT_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_TEMP   = 3'd4;

    localparam logic [SIZE_W-1:0]    WIDTH_RESET  = 9'd256;
    localparam logic [SIZE_W-1:0]    HEIGHT_RESET = 9'd256;
    localparam logic [COEF_W-1:0]    COEF_RESET   = 16'd0;
    localparam logic [TEMP_BITS-1:0] SINK_RESET   = 32'd19660800;

    typedef struct packed {
        logic has_above;
        logic interior;
        logic has_sink;
        logic frame_done;
    } t_cell_ctl;

    typedef struct packed {
        logic                 above_v;
        logic [TEMP_BITS-1:0] above_val;
        logic                 sink_v;
        logic                 frame_done;
        logic [TEMP_BITS-1:0] max_val;
    } t_result_entry;

    typedef struct packed {
        logic [TEMP_BITS-1:0] row_above;
        logic [TEMP_BITS-1:0] row_two_above;
        logic [TEMP_BITS-1:0] heat;
    } t_line_word;

    localparam int LINE_W = $bits(t_line_word);

endpackage

`default_nettype wire

// ===== hw/rtl/heat_stencil_sweep.sv =====
// One explicit time step of 2D heat diffusion on a raster stream of grid cells.
// Input channel: i_valid/o_stall carry one previous-step temperature and its
// dt*source term per request, in raster order. Output channel: o_valid/i_stall
// carry updated cells, one row behind the input. A row-0 request yields no
// result, any other request yields the cell above it, and a last-row request
// also yields its own border cell; frame_end and max_change mark the final one.
// Configuration: i_cfg_valid/o_cfg_ready with a register index and data; the
// port is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. Throughput: one request per cycle
// while o_stall is low, set by one read and one write of the line-buffer
// memory per request. Last-row requests give two results each, so there the
// receiver sets the pace. The result for the cell above passes memory read,
// difference, multiply, round, saturate and the result queue, in that order.
// When the receiver stalls, results wait in an 8-entry queue; o_stall rises
// once the queue and the four pipeline stages together hold 8 requests.
// Reset clears the row and column counters, the running maximum, the queue and
// the pipeline valid bits, and loads the configuration reset values. The line
// buffers are not cleared: the first two rows of a frame never use old contents.
`default_nettype none

module heat_stencil_sweep (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]     i_temperature,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]     i_heat_step,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [hsw_pkg::TEMP_BITS-1:0]     o_new_temp,
    output logic                                   o_frame_end,
    output logic      [hsw_pkg::TEMP_BITS-1:0]     o_max_change,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hsw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hsw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import hsw_pkg::*;

    logic [SIZE_W-1:0]    r_grid_width, r_grid_height;
    logic [COEF_W-1:0]    r_coef_x, r_coef_y;
    logic [TEMP_BITS-1:0] r_sink_temp;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;

    logic [SIZE_W-1:0]     w_use, h_use;
    logic                  accept;
    logic                  row_end, last_row, border;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      n_row;
    t_cell_ctl             ctl;
    t_line_word            rd_word;
    t_line_word            wr_word;
    logic [LINE_W-1:0]     rd_bits;
    logic [PIPE_CNT_W-1:0] inflight;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  push;
    t_result_entry         entry;

    always_comb begin
        if (r_grid_width < SIZE_W'(MIN_SIZE)) begin
            w_use = SIZE_W'(MIN_SIZE);
        end else if (r_grid_width > SIZE_W'(MAX_WIDTH)) begin
            w_use = SIZE_W'(MAX_WIDTH);
        end else begin
            w_use = r_grid_width;
        end
        if (r_grid_height < SIZE_W'(MIN_SIZE)) begin
            h_use = SIZE_W'(MIN_SIZE);
        end else if (r_grid_height > SIZE_W'(MAX_HEIGHT)) begin
            h_use = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_use = r_grid_height;
        end
    end

    always_comb begin
        o_stall  = (CREDIT_W'(inflight) + CREDIT_W'(fifo_count)) >= CREDIT_W'(FIFO_DEPTH);
        accept   = i_valid && !o_stall;
        row_end  = (SIZE_W'(r_col) + SIZE_W'(1)) >= w_use;
        last_row = (SIZE_W'(r_row) + SIZE_W'(1)) >= h_use;
        border   = (r_row == ROW_W'(1)) || (r_col == '0) || row_end;
        ctl.has_above  = (r_row != '0);
        ctl.interior   = (r_row != '0) && !border;
        ctl.has_sink   = last_row;
        ctl.frame_done = row_end && last_row;
        n_col = row_end ? '0 : r_col + COL_W'(1);
        if (row_end) begin
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_row = r_row;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= WIDTH_RESET;
            r_grid_height <= HEIGHT_RESET;
            r_coef_x      <= COEF_RESET;
            r_coef_y      <= COEF_RESET;
            r_sink_temp   <= SINK_RESET;
            r_col         <= '0;
            r_row         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[SIZE_W-1:0];
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[SIZE_W-1:0];
                    CFG_COEF_X:      r_coef_x      <= i_cfg_data[COEF_W-1:0];
                    CFG_COEF_Y:      r_coef_y      <= i_cfg_data[COEF_W-1:0];
                    CFG_SINK_TEMP:   r_sink_temp   <= i_cfg_data[TEMP_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // After the first request, the read data holds the entry of the current
    // column: each request fetches the entry of the column that follows it.
    always_comb begin
        rd_word = t_line_word'(rd_bits);
        wr_word.row_above     = i_temperature;
        wr_word.row_two_above = rd_word.row_above;
        wr_word.heat          = i_heat_step;
    end

    hsw_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (wr_word),
        .i_rd_en   (accept),
        .i_rd_addr (n_col),
        .o_rd_data (rd_bits)
    );

    hsw_stencil_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_ctl       (ctl),
        .i_center    (rd_word.row_above),
        .i_north     (rd_word.row_two_above),
        .i_heat      (rd_word.heat),
        .i_south     (i_temperature),
        .i_east      (rd_word.row_above),
        .i_coef_x    (r_coef_x),
        .i_coef_y    (r_coef_y),
        .i_sink_temp (r_sink_temp),
        .o_inflight  (inflight),
        .o_push      (push),
        .o_entry     (entry)
    );

    hsw_result_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_sink_temp  (r_sink_temp),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_new_temp   (o_new_temp),
        .o_frame_end  (o_frame_end),
        .o_max_change (o_max_change),
        .o_count      (fifo_count)
    );

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CREDIT_W'(inflight) + CREDIT_W'(fifo_count)) <= CREDIT_W'(FIFO_DEPTH))
        else $error("More requests in flight than the result queue can hold.");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ctl.frame_done |=> (r_row == '0) && (r_col == '0))
        else $error("Raster position not restarted after the final cell.");

    a_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (inflight != '0))
        else $error("Accepted request did not enter the datapath.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/hsw_ram.sv =====
`default_nettype none

module hsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/hsw_stencil_dp.sv =====
`default_nettype none

module hsw_stencil_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire hsw_pkg::t_cell_ctl               i_ctl,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]    i_center,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]    i_north,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]    i_heat,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]    i_south,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]    i_east,
    input  wire logic [hsw_pkg::COEF_W-1:0]       i_coef_x,
    input  wire logic [hsw_pkg::COEF_W-1:0]       i_coef_y,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]    i_sink_temp,
    output logic      [hsw_pkg::PIPE_CNT_W-1:0]   o_inflight,
    output logic                                  o_push,
    output hsw_pkg::t_result_entry                o_entry
);

    import hsw_pkg::*;

    logic                 r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_cell_ctl            r_s1_ctl, r_s2_ctl, r_s3_ctl, r_s4_ctl;
    logic [TEMP_BITS-1:0] r_west;
    logic [TEMP_BITS-1:0] r_s1_c, r_s1_n, r_s1_w, r_s1_s, r_s1_h;
    logic [TEMP_BITS-1:0] r_s2_c, r_s2_h, r_s3_c, r_s3_h, r_s4_c;
    logic [DIFF_W-1:0]    r_s2_dxx, r_s2_dyy;
    logic [PROD_W-1:0]    r_s3_pxx, r_s3_pyy;
    logic [UPD_W-1:0]     r_s4_update;
    logic [TEMP_BITS-1:0] r_max;

    logic [DIFF_W-1:0]        n_dxx, n_dyy;
    logic signed [PROD_W-1:0] n_pxx, n_pyy;
    logic [SUM_W-1:0]         n_sum;
    logic [RND_W-1:0]         n_rnd;
    logic [UPD_W-1:0]         n_update;
    logic [NT_W-1:0]          n_nt;
    logic [TEMP_BITS-1:0]     n_nt_sat;
    logic [UPD_W-1:0]         n_mag_full;
    logic [TEMP_BITS-1:0]     n_mag;
    logic [TEMP_BITS-1:0]     n_max;

    // The west neighbor is the center of the previous request on the same row.
    always_comb begin
        n_dxx = DIFF_W'(i_east) + DIFF_W'(r_s1_w) - {2'b00, r_s1_c, 1'b0};
        n_dyy = DIFF_W'(r_s1_n) + DIFF_W'(r_s1_s) - {2'b00, r_s1_c, 1'b0};
    end

    always_comb begin
        n_pxx = $signed(r_s2_dxx) * $signed({1'b0, i_coef_x});
        n_pyy = $signed(r_s2_dyy) * $signed({1'b0, i_coef_y});
    end

    always_comb begin
        n_sum = {r_s3_pxx[PROD_W-1], r_s3_pxx} + {r_s3_pyy[PROD_W-1], r_s3_pyy}
              + SUM_W'(ROUND_HALF);
        n_rnd = n_sum[SUM_W-1:FRAC_BITS];
        n_update = {n_rnd[RND_W-1], n_rnd} + UPD_W'(r_s3_h);
    end

    always_comb begin
        n_nt = NT_W'(r_s4_c) + {r_s4_update[UPD_W-1], r_s4_update};
        if (n_nt[NT_W-1]) begin
            n_nt_sat = '0;
        end else if (|n_nt[NT_W-2:TEMP_BITS]) begin
            n_nt_sat = '1;
        end else begin
            n_nt_sat = n_nt[TEMP_BITS-1:0];
        end
        n_mag_full = r_s4_update[UPD_W-1] ? (UPD_W'(0) - r_s4_update) : r_s4_update;
        n_mag = (|n_mag_full[UPD_W-1:TEMP_BITS]) ? '1 : n_mag_full[TEMP_BITS-1:0];
        n_max = (r_s4_ctl.interior && (n_mag > r_max)) ? n_mag : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_max      <= '0;
        end else begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            if (r_s4_valid) begin
                r_max <= r_s4_ctl.frame_done ? '0 : n_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_west   <= i_center;
            r_s1_ctl <= i_ctl;
            r_s1_c   <= i_center;
            r_s1_n   <= i_north;
            r_s1_w   <= r_west;
            r_s1_s   <= i_south;
            r_s1_h   <= i_heat;
        end
        r_s2_ctl    <= r_s1_ctl;
        r_s2_c      <= r_s1_c;
        r_s2_h      <= r_s1_h;
        r_s2_dxx    <= n_dxx;
        r_s2_dyy    <= n_dyy;
        r_s3_ctl    <= r_s2_ctl;
        r_s3_c      <= r_s2_c;
        r_s3_h      <= r_s2_h;
        r_s3_pxx    <= n_pxx;
        r_s3_pyy    <= n_pyy;
        r_s4_ctl    <= r_s3_ctl;
        r_s4_c      <= r_s3_c;
        r_s4_update <= n_update;
    end

    assign o_inflight = PIPE_CNT_W'(r_s1_valid) + PIPE_CNT_W'(r_s2_valid)
                      + PIPE_CNT_W'(r_s3_valid) + PIPE_CNT_W'(r_s4_valid);

    assign o_push = r_s4_valid && (r_s4_ctl.has_above || r_s4_ctl.has_sink);

    always_comb begin
        o_entry.above_v    = r_s4_ctl.has_above;
        o_entry.above_val  = r_s4_ctl.interior ? n_nt_sat : i_sink_temp;
        o_entry.sink_v     = r_s4_ctl.has_sink;
        o_entry.frame_done = r_s4_ctl.frame_done;
        o_entry.max_val    = r_s4_ctl.frame_done ? n_max : '0;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hsw_result_fifo.sv =====
`default_nettype none

module hsw_result_fifo (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire hsw_pkg::t_result_entry           i_entry,
    input  wire logic [hsw_pkg::TEMP_BITS-1:0]    i_sink_temp,
    input  wire logic                             i_stall,
    output logic                                  o_valid,
    output logic      [hsw_pkg::TEMP_BITS-1:0]    o_new_temp,
    output logic                                  o_frame_end,
    output logic      [hsw_pkg::TEMP_BITS-1:0]    o_max_change,
    output logic      [hsw_pkg::FIFO_CNT_W-1:0]   o_count
);

    import hsw_pkg::*;

    t_result_entry         r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  r_half;

    t_result_entry         head;
    logic                  show_above;
    logic                  last;
    logic                  take;
    logic                  pop;

    always_comb begin
        head       = r_mem[r_rd_ptr];
        show_above = head.above_v && !r_half;
        last       = !(show_above && head.sink_v);
        o_valid    = (r_count != '0);
        take       = o_valid && !i_stall;
        pop        = take && last;
        o_new_temp   = show_above ? head.above_val : i_sink_temp;
        o_frame_end  = !show_above && head.frame_done;
        o_max_change = o_frame_end ? head.max_val : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_half   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop);
            if (take) begin
                r_half <= !last;
            end
        end
    end

    assign o_count = r_count;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("Result queue written while full.");

    a_half_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_count != '0))
        else $error("Second result pending with an empty queue.");

    a_second_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !last |=> r_half && $stable(r_rd_ptr))
        else $error("Queue entry dropped before its sink result.");
`endif

endmodule

`default_nettype wire

// ===== verif/heat_stencil_sweep_checker.sv =====
module heat_stencil_sweep_checker
    import hsw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    input  wire logic                  i_req_stall,
    input  wire logic [TEMP_BITS-1:0]  i_temperature,
    input  wire logic [TEMP_BITS-1:0]  i_heat_step,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_stall,
    input  wire logic [TEMP_BITS-1:0]  i_new_temp,
    input  wire logic                  i_frame_end,
    input  wire logic [TEMP_BITS-1:0]  i_max_change,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TEMP_BITS-1:0] new_temp;
        logic                 frame_end;
        logic [TEMP_BITS-1:0] max_change;
    } cell_result_t;

    logic [TEMP_BITS-1:0] upper_row [MAX_WIDTH];
    logic [TEMP_BITS-1:0] upper2_row [MAX_WIDTH];
    logic [TEMP_BITS-1:0] heat_row [MAX_WIDTH];
    int                   col_pos;
    int                   row_pos;
    logic [TEMP_BITS-1:0] peak_change;

    logic [SIZE_W-1:0]    width_reg;
    logic [SIZE_W-1:0]    height_reg;
    logic [COEF_W-1:0]    coef_x_reg;
    logic [COEF_W-1:0]    coef_y_reg;
    logic [TEMP_BITS-1:0] sink_reg;

    cell_result_t expected_cells [$];
    cell_result_t want;

    function automatic int clamp_dim(logic [SIZE_W-1:0] v, int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic advance_sweep(input logic [TEMP_BITS-1:0] temp,
                                 input logic [TEMP_BITS-1:0] heat);
        int                   w;
        int                   h;
        bit                   row_end;
        bit                   last_row;
        logic [TEMP_BITS-1:0] cell_val;
        longint               ctr;
        longint               east;
        longint               west;
        longint               north;
        longint               south;
        longint               kx;
        longint               ky;
        longint               hk;
        longint               dxx;
        longint               dyy;
        longint               diff;
        longint               upd;
        longint               nt;
        longint               temp_ceiling;
        longint unsigned      mag;
        longint unsigned      mag_cap;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        row_end = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        if (row_pos != 0) begin
            if (row_pos == 1 || col_pos == 0 || row_end) begin
                cell_val = sink_reg;
            end else begin
                // The west neighbor has already been shifted into the older line.
                ctr = upper_row[col_pos];
                east = upper_row[col_pos + 1];
                west = upper2_row[col_pos - 1];
                north = upper2_row[col_pos];
                south = temp;
                kx = coef_x_reg;
                ky = coef_y_reg;
                hk = heat_row[col_pos];
                dxx = east - 2 * ctr + west;
                dyy = north - 2 * ctr + south;
                diff = dxx * kx + dyy * ky;
                upd = ((diff + ROUND_HALF) >>> FRAC_BITS) + hk;
                nt = ctr + upd;
                temp_ceiling = (longint'(1) << TEMP_BITS) - 1;
                mag = (upd < 0) ? -upd : upd;
                mag_cap = 64'hFFFF_FFFF;
                if (mag > mag_cap) mag = mag_cap;
                if (mag[31:0] > peak_change) peak_change = mag[31:0];
                if (nt < 0) nt = 0;
                if (nt > temp_ceiling) nt = temp_ceiling;
                cell_val = nt[TEMP_BITS-1:0];
            end
            expected_cells.push_back('{new_temp: cell_val, frame_end: 1'b0, max_change: '0});
        end
        if (last_row) begin
            expected_cells.push_back('{new_temp: sink_reg, frame_end: row_end,
                                       max_change: row_end ? peak_change : '0});
        end
        upper2_row[col_pos] = upper_row[col_pos];
        upper_row[col_pos] = temp;
        heat_row[col_pos] = heat;
        if (row_end) begin
            col_pos = 0;
            if (last_row) begin
                row_pos = 0;
                peak_change = '0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            col_pos = 0;
            row_pos = 0;
            peak_change = '0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            coef_x_reg = COEF_RESET;
            coef_y_reg = COEF_RESET;
            sink_reg = SINK_RESET;
            expected_cells.delete();
            o_fail_count = 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_cells.size() == 0) begin
                    $error("new_temp: no result expected, actual %0h", i_new_temp);
                    o_fail_count++;
                end else begin
                    want = expected_cells.pop_front();
                    if (i_new_temp !== want.new_temp) begin
                        $error("new_temp: expected %0h, actual %0h", want.new_temp, i_new_temp);
                        o_fail_count++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               want.frame_end, i_frame_end);
                        o_fail_count++;
                    end
                    if (i_max_change !== want.max_change) begin
                        $error("max_change: expected %0h, actual %0h",
                               want.max_change, i_max_change);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  width_reg = i_cfg_data[SIZE_W-1:0];
                    CFG_GRID_HEIGHT: height_reg = i_cfg_data[SIZE_W-1:0];
                    CFG_COEF_X:      coef_x_reg = i_cfg_data[COEF_W-1:0];
                    CFG_COEF_Y:      coef_y_reg = i_cfg_data[COEF_W-1:0];
                    CFG_SINK_TEMP:   sink_reg = i_cfg_data[TEMP_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                advance_sweep(i_temperature, i_heat_step);
            end
        end
        o_outstanding = expected_cells.size();
    end

endmodule

// ===== verif/heat_stencil_sweep_tb.sv =====
module heat_stencil_sweep_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsw_pkg::*;

    typedef enum {FILL_RANDOM, FILL_SMOOTH, FILL_EXTREME, FILL_TINY} fill_style_t;
    typedef enum {FLOW_OPEN, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

    localparam int                   CELL_BUDGET  = 120;
    localparam int                   DRAIN_CYCLES = 12;
    localparam int                   HOLD_CYCLES  = 200;
    localparam logic [TEMP_BITS-1:0] MAX_TEMP     = '1;
    localparam logic [TEMP_BITS-1:0] ROOM_TEMP    = 32'd19660800;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [TEMP_BITS-1:0]  i_temperature = '0;
    logic [TEMP_BITS-1:0]  i_heat_step = '0;
    logic                  o_valid;
    logic                  i_stall;
    logic [TEMP_BITS-1:0]  o_new_temp;
    logic                  o_frame_end;
    logic [TEMP_BITS-1:0]  o_max_change;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int                   fail_count;
    int                   outstanding;
    int                   burst_left = 0;
    int                   gap_limit = 0;
    int                   cells_sent = 0;
    bit                   want_hold = 1'b0;
    fill_style_t          content_style = FILL_RANDOM;
    logic [TEMP_BITS-1:0] base_temp = ROOM_TEMP;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    heat_stencil_sweep i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_temperature (i_temperature),
        .i_heat_step   (i_heat_step),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_new_temp    (o_new_temp),
        .o_frame_end   (o_frame_end),
        .o_max_change  (o_max_change),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    heat_stencil_sweep_checker i_sweep_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_temperature (i_temperature),
        .i_heat_step   (i_heat_step),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_new_temp    (o_new_temp),
        .i_frame_end   (o_frame_end),
        .i_max_change  (o_max_change),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    function automatic logic [CFG_DATA_W-1:0] with_noise_above(logic [CFG_DATA_W-1:0] value,
                                                              int bits);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom();
        for (int i = 0; i < bits; i++) data[i] = value[i];
        return data;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'd32768;
            2: return '1;
            3: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 8000);
        endcase
    endfunction

    function automatic logic [TEMP_BITS-1:0] pick_sink();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return MAX_TEMP;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [TEMP_BITS-1:0] cell_temp();
        case (content_style)
            FILL_RANDOM: return $urandom();
            FILL_SMOOTH: return base_temp + $urandom_range(0, 4095) - 2048;
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return MAX_TEMP;
                    2: return 1;
                    default: return MAX_TEMP - 1;
                endcase
            end
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [TEMP_BITS-1:0] cell_heat();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return MAX_TEMP;
            2: return $urandom();
            default: return $urandom_range(0, 131071);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_grid(input int w_val, input int h_val, input logic [COEF_W-1:0] cx,
                            input logic [COEF_W-1:0] cy, input logic [TEMP_BITS-1:0] sink);
        write_reg(CFG_GRID_WIDTH, with_noise_above(w_val, SIZE_W));
        write_reg(CFG_GRID_HEIGHT, with_noise_above(h_val, SIZE_W));
        write_reg(CFG_COEF_X, with_noise_above(cx, COEF_W));
        write_reg(CFG_COEF_Y, with_noise_above(cy, COEF_W));
        write_reg(CFG_SINK_TEMP, sink);
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(CFG_SINK_TEMP + 1, 2 ** CFG_IDX_W - 1), $urandom());
        end
    endtask

    task automatic push_cell(input logic [TEMP_BITS-1:0] temp, input logic [TEMP_BITS-1:0] heat);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_limit);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid = 1'b1;
        i_temperature = temp;
        i_heat_step = heat;
        burst_left--;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic stop_cells();
        @(negedge i_clk);
        i_valid = 1'b0;
        burst_left = 0;
    endtask

    task automatic settle();
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic sweep(input int count);
        for (int n = 0; n < count; n++) push_cell(cell_temp(), cell_heat());
        cells_sent += count;
        stop_cells();
        settle();
    endtask

    initial begin
        int span;
        int period;
        bit held;
        flow_mode_t mode;
        held = 1'b0;
        i_stall = 1'b0;
        forever begin
            if (want_hold && !held) begin
                held = 1'b1;
                @(negedge i_clk);
                i_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end
            mode = flow_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 80);
            period = $urandom_range(2, 4);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    FLOW_OPEN:  i_stall = 1'b0;
                    FLOW_LIGHT: i_stall = ($urandom_range(0, 99) < 30);
                    FLOW_HEAVY: i_stall = ($urandom_range(0, 99) < 75);
                    default:    i_stall = ((k % period) != 0);
                endcase
            end
        end
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [TEMP_BITS-1:0] corner_temps [9];
        logic [TEMP_BITS-1:0] corner_heats [9];
        int w;
        int h;
        int w_val;
        int h_val;
        int frames;
        int pick;
        corner_temps = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                         32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 32'h0000_0000, 32'h0012_3456};
        corner_heats = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                         32'h0000_8000, 32'h9000_0000, 32'h0000_0000,
                         32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Coefficients and sink temperature keep their reset values here.
        write_reg(CFG_GRID_WIDTH, MIN_SIZE);
        write_reg(CFG_GRID_HEIGHT, MIN_SIZE);
        for (int i = 0; i < 9; i++) push_cell(corner_temps[i], corner_heats[i]);
        stop_cells();
        settle();

        // A checkerboard of the temperature extremes drives both saturation limits.
        set_grid(4, 4, '1, '1, '0);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                push_cell(((r + c) % 2 == 1) ? MAX_TEMP : '0, (c == 1) ? MAX_TEMP : '0);
            end
        end
        stop_cells();
        settle();

        // Shrink the grid in the middle of row 2, past the current column.
        gap_limit = 3;
        content_style = FILL_SMOOTH;
        set_grid(20, 6, pick_coef(), pick_coef(), pick_sink());
        sweep(50);
        write_reg(CFG_GRID_WIDTH, with_noise_above(5, SIZE_W));
        write_reg(CFG_GRID_HEIGHT, with_noise_above(5, SIZE_W));
        sweep(11);

        // Widest grid, with a long receiver hold-off so the block backs up.
        gap_limit = 2;
        base_temp = ROOM_TEMP;
        set_grid(MAX_WIDTH, 2, pick_coef(), pick_coef(), pick_sink());
        want_hold = 1'b1;
        sweep(MAX_WIDTH * MIN_SIZE);

        content_style = FILL_RANDOM;
        set_grid(1, 2 ** SIZE_W - 1, pick_coef(), pick_coef(), pick_sink());
        sweep(MIN_SIZE * MAX_HEIGHT);

        cells_sent = 0;
        while (cells_sent < CELL_BUDGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) w = $urandom_range(3, 10);
            else if (pick < 90) w = $urandom_range(11, 40);
            else w = $urandom_range(41, 120);
            if (w > 40) h = $urandom_range(3, 6);
            else if ($urandom_range(0, 9) < 8) h = $urandom_range(3, 8);
            else h = $urandom_range(9, 16);
            w_val = w;
            h_val = h;
            if (w == MIN_SIZE && $urandom_range(0, 1) == 1) w_val = $urandom_range(0, 2);
            if (h == MIN_SIZE && $urandom_range(0, 1) == 1) h_val = $urandom_range(0, 2);
            frames = (w * h < 60) ? $urandom_range(1, 3) : 1;
            gap_limit = $urandom_range(0, 6);
            content_style = fill_style_t'($urandom_range(0, 3));
            base_temp = ($urandom_range(0, 1) == 1) ? ROOM_TEMP : $urandom();
            set_grid(w_val, h_val, pick_coef(), pick_coef(), pick_sink());
            sweep(frames * w * h);
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
